// ----- hdl/b64sd_pkg.sv -----
`timescale 1ns / 1ps
// b64sd_pkg: shared types, character codes and the alphabet lookup
// for the base64 stream decoder; no dependencies

package b64sd_pkg;

  localparam logic [7:0]  CharPad    = 8'h3D;  // '='
  localparam logic [7:0]  CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0]  CharSlash  = 8'h2F;  // '/'
  localparam logic [5:0]  SextetPlus  = 6'd62;
  localparam logic [5:0]  SextetSlash = 6'd63;
  localparam logic [15:0] LimitReset = 16'hFFFF;

  // pending bit counts, always even and below eight
  localparam logic [2:0] Pend0 = 3'd0;
  localparam logic [2:0] Pend2 = 3'd2;
  localparam logic [2:0] Pend4 = 3'd4;
  localparam logic [2:0] Pend6 = 3'd6;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // alphabet lookup: hit is low for anything outside the standard alphabet
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t    res;
    logic [7:0] diff;
    res  = '0;
    diff = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      diff      = ch - 8'h41;
      res.hit   = 1'b1;
      res.value = diff[5:0];
    end else if (ch inside {[8'h61:8'h7A]}) begin
      diff      = ch - 8'h61 + 8'd26;
      res.hit   = 1'b1;
      res.value = diff[5:0];
    end else if (ch inside {[8'h30:8'h39]}) begin
      diff      = ch - 8'h30 + 8'd52;
      res.hit   = 1'b1;
      res.value = diff[5:0];
    end else if (ch == CharPlus) begin
      res.hit   = 1'b1;
      res.value = SextetPlus;
    end else if (ch == CharSlash) begin
      res.hit   = 1'b1;
      res.value = SextetSlash;
    end
    return res;
  endfunction

endpackage

// ----- hdl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// base64_stream_decoder: lenient base64 decoder, one character per beat
// depends on b64sd_pkg for the alphabet lookup and character codes
//
// usage
//   slave side: one ascii character per beat in s_axis_tdata_i; a beat with
//   s_axis_tlast_i high is the end-of-text marker and its data is ignored
//   master side: exactly one result beat per input beat, in order
//     tdata = {byte_count[15:0], decoded_byte[7:0]}
//     tuser = {overflow, byte_valid}, tlast = done
//   characters outside the alphabet are skipped (result with byte_valid low);
//   the first '=' stops decoding until the end beat; once the byte count
//   would pass output_limit the overflow flag rises and stays until the end
//   beat, which reports the final count and clears all decode state
// latency and throughput
//   a result appears in the cycle after its beat is accepted; one beat per
//   cycle is sustained while tready is high, set by the single result register
// stall
//   when the receiver holds tready low the result register keeps its beat and
//   the slave side stalls with it; s_axis_tready_o is high whenever
//   the result register is empty or being drained in the same cycle
// reset
//   rst_ni clears decode state and the result valid, output_limit
//   returns to 65535; cfg_we_i takes effect at once, so write it while idle

module base64_stream_decoder
  import b64sd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: output_limit
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // end_of_text
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] decoded_byte, [23:8] byte_count
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] overflow
  output logic        m_axis_tlast_o    // done_res
);

  // configuration register
  logic [15:0] limit_q;

  // decode state
  logic [11:0] acc_q, acc_d;
  logic [2:0]  pend_q, pend_d;
  logic [15:0] count_q, count_d;
  logic        pad_q, pad_d;
  logic        fail_q, fail_d;

  // result register
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;
  logic        out_last_q;

  logic    in_fire;
  sextet_t sx;
  logic [7:0] byte_val;
  logic       byte_due;

  // take a beat whenever the result register is free or drains now
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign sx = sextet_of(s_axis_tdata_i);

  always_comb begin
    acc_d      = acc_q;
    pend_d     = pend_q;
    count_d    = count_q;
    pad_d      = pad_q;
    fail_d     = fail_q;
    byte_val   = '0;
    byte_due   = 1'b0;
    out_data_d = '0;
    out_user_d = '0;

    if (s_axis_tlast_i) begin
      // end beat: report and clear
      out_data_d = {count_q, 8'h00};
      out_user_d = {fail_q, 1'b0};
      acc_d      = '0;
      pend_d     = Pend0;
      count_d    = '0;
      pad_d      = 1'b0;
      fail_d     = 1'b0;
    end else begin
      if (!pad_q && !fail_q) begin
        if (s_axis_tdata_i == CharPad) begin
          pad_d = 1'b1;
        end else if (sx.hit) begin
          acc_d = {acc_q[5:0], sx.value};
          // six more bits make a byte whenever any were pending
          case (pend_q)
            Pend0: begin
              pend_d = Pend6;
            end
            Pend2: begin
              pend_d   = Pend0;
              byte_due = 1'b1;
              byte_val = acc_d[7:0];
            end
            Pend4: begin
              pend_d   = Pend2;
              byte_due = 1'b1;
              byte_val = acc_d[9:2];
            end
            Pend6: begin
              pend_d   = Pend4;
              byte_due = 1'b1;
              byte_val = acc_d[11:4];
            end
            default: begin
              pend_d = Pend0;
            end
          endcase
          if (byte_due) begin
            if (count_q >= limit_q) begin
              fail_d   = 1'b1;
              byte_due = 1'b0;
              byte_val = '0;
            end else begin
              count_d = count_q + 16'd1;
            end
          end
        end
      end
      out_data_d = {count_d, byte_val};
      out_user_d = {fail_d, byte_due};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pend_q  <= Pend0;
      count_q <= '0;
      pad_q   <= 1'b0;
      fail_q  <= 1'b0;
    end else if (in_fire) begin
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      count_q <= count_d;
      pad_q   <= pad_d;
      fail_q  <= fail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
      out_last_q  <= s_axis_tlast_i;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- test/base64_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// base64_stream_decoder_tb: self-checking bench for the base64 stream decoder
// drives character beats, predicts every result beat, depends on b64sd_pkg

module base64_stream_decoder_tb;
  import b64sd_pkg::*;

  // one result beat, field by field
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    logic        done;
    logic [15:0] byte_count;
    logic        overflow;
  } decode_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;    // [7:0] char_code
  logic        s_axis_tlast_i  = 1'b0;  // end_of_text
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;          // [7:0] decoded_byte, [23:8] byte_count
  logic [1:0]  m_axis_tuser_o;          // [0] byte_valid, [1] overflow
  logic        m_axis_tlast_o;          // done_res

  base64_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder state as the bench expects it
  logic [11:0] exp_acc;
  logic [2:0]  exp_pending;
  logic [15:0] exp_count;
  logic        exp_pad_seen;
  logic        exp_failed;
  logic [15:0] exp_limit;

  decode_result_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int total_beats    = 0;
  int decoding_beats = 0;   // beats that moved the decoder, ignored ones excluded
  int results_seen   = 0;
  int strings_sent   = 0;
  int limit_settings = 0;

  // receiver back-pressure, one decision per cycle
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // six-bit value of a standard alphabet character, -1 when outside
  function automatic int alphabet_value(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 52;
    if (ch == CharPlus) return SextetPlus;
    if (ch == CharSlash) return SextetSlash;
    return -1;
  endfunction

  // encoder direction, used to build well-formed strings
  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == SextetPlus) return CharPlus;
    return CharSlash;
  endfunction

  task automatic clear_decode_state();
    exp_acc      = '0;
    exp_pending  = Pend0;
    exp_count    = '0;
    exp_pad_seen = 1'b0;
    exp_failed   = 1'b0;
  endtask

  // advance the expected state by one accepted beat and queue its result
  task automatic predict_beat(input logic [7:0] ch, input logic last);
    decode_result_t r;
    int             sextet;
    int             bits;
    r = '0;
    if (last) begin
      r.done       = 1'b1;
      r.byte_count = exp_count;
      r.overflow   = exp_failed;
      decoding_beats++;
      clear_decode_state();
    end else begin
      if (!exp_pad_seen && !exp_failed) begin
        if (ch == CharPad) begin
          exp_pad_seen = 1'b1;
        end else begin
          sextet = alphabet_value(ch);
          if (sextet >= 0) begin
            decoding_beats++;
            exp_acc = {exp_acc[5:0], sextet[5:0]};
            bits    = exp_pending + 6;
            if (bits >= 8) begin
              bits -= 8;
              // a byte is due; it is dropped once the limit is reached
              if (exp_count >= exp_limit) begin
                exp_failed = 1'b1;
              end else begin
                r.byte_valid   = 1'b1;
                r.decoded_byte = 8'(exp_acc >> bits);
                exp_count++;
              end
            end
            exp_pending = 3'(bits);
          end
        end
      end
      r.byte_count = exp_count;
      r.overflow   = exp_failed;
    end
    pending_results.push_back(r);
  endtask

  // one input beat; valid stays high afterwards unless the next call idles
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    total_beats++;
    predict_beat(ch, last);
  endtask

  task automatic send_text(input string text);
    foreach (text[i]) send_char(text[i], 1'b0);
  endtask

  // end-of-text beat, its data bits are don't-care for the block
  task automatic send_end();
    send_char(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_limit = value;
    limit_settings++;
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] act);
    if (act !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, act);
      mismatches++;
    end
  endtask

  // result checker, samples each accepted result beat
  always @(posedge clk_i) begin : result_check
    decode_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("byte_valid", 16'(want.byte_valid), 16'(m_axis_tuser_o[0]));
        check_field("decoded_byte", 16'(want.decoded_byte), 16'(m_axis_tdata_o[7:0]));
        check_field("done_res", 16'(want.done), 16'(m_axis_tlast_o));
        check_field("byte_count", want.byte_count, m_axis_tdata_o[23:8]);
        check_field("overflow", 16'(want.overflow), 16'(m_axis_tuser_o[1]));
      end
    end
  end

  // plain decode at the reset limit, with a nul, a high code and a stray
  // punctuation character mixed in
  task automatic test_plain_decode();
    send_text("TW");
    send_char(8'h00, 1'b0);
    send_text("Fu");
    send_char(8'hFF, 1'b0);
    send_char("!", 1'b0);
    send_end();
  endtask

  // pad ends decoding, the characters after it must not count
  task automatic test_pad_and_skip();
    send_text("QQ=Zm");
    send_end();
  endtask

  // limit of one: second byte overflows, then limit zero overflows at once
  task automatic test_limit_overflow();
    write_limit(16'd1);
    send_text("+/+/");
    send_end();
    write_limit(16'd0);
    send_text("9z");
    send_end();
  endtask

  // mostly well-formed strings with random content, some noise and breakage
  task automatic send_random_string();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(0, 12);
      repeat (len) send_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      len = $urandom_range(0, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
        send_char(sextet_char($urandom_range(0, 63)), 1'b0);
      end
      // proper padding on most strings, sometimes followed by junk
      if (kind <= 6 && (len % 4) >= 2) begin
        repeat (4 - (len % 4)) send_char(CharPad, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_char(sextet_char($urandom_range(0, 63)), 1'b0);
          send_char(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    send_end();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 3; k++) begin
      case (limit_settings % 4)
        0:       write_limit(LimitReset);
        1:       write_limit(16'($urandom_range(1, 24)));
        2:       write_limit(16'($urandom_range(0, 16'hFFFF)));
        default: write_limit(16'd0);
      endcase
      stop_at = total_beats + 135;
      while (total_beats < stop_at) send_random_string();
    end
  endtask

  initial begin
    exp_limit = LimitReset;
    clear_decode_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_decode();
    test_pad_and_skip();
    test_limit_overflow();
    test_random_phase(0, 0);
    test_random_phase(69, 0);
    test_random_phase(0, 69);
    test_random_phase(27, 27);

    wait_idle();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("run covered %0d beats (%0d moved the decoder) in %0d strings over %0d limit settings",
             total_beats, decoding_beats, strings_sent, limit_settings);
    $display("%0d result beats checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- base64_stream_decoder.f -----
hdl/b64sd_pkg.sv
hdl/base64_stream_decoder.sv
test/base64_stream_decoder_tb.sv
